@@ hdl/lsl_pkg.sv @@
`timescale 1ns / 1ps
package lsl_pkg;
   localparam int unsigned DefaultWidth = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_D,
      ST_RED_P,
      ST_SEEK,
      ST_DBL_UV,
      ST_DBL_VV,
      ST_DBL_TT,
      ST_DBL_DT,
      ST_DBL_FIN,
      ST_ADD_PU,
      ST_ADD_DT,
      ST_ADD_PV,
      ST_ADD_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
   } mul_ctl_type;
endpackage

@@ hdl/lsl_if.sv @@
`timescale 1ns / 1ps
interface lsl_if #(parameter int unsigned W = 32) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] a;
   logic [W-1:0] b;
   logic [W-1:0] c;
   logic [W-1:0] d;
   logic         e;
   modport source (output valid, a, b, c, d, e, input ready);
   modport sink   (input valid, a, b, c, d, e, output ready);
endinterface

@@ hdl/lsl_mulmod.sv @@
`timescale 1ns / 1ps
// bit-serial modular multiply: acc = a*b mod n, msb of b first, one bit a cycle
// also used as a serial reducer: with a = 1 it computes b mod n
// done pulses the cycle after the last bit, when prod holds the result
module lsl_mulmod #(
   parameter int unsigned WIDTH = lsl_pkg::DefaultWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lsl_pkg::mul_ctl_type  ctl,
   input  logic [WIDTH-1:0]      a_in,
   input  logic [WIDTH-1:0]      b_in,
   input  logic [WIDTH-1:0]      n_in,
   output logic [WIDTH-1:0]      prod,
   output logic                  done
);
   import lsl_pkg::*;
   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in, b_ff, b_in_nx;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   dbl, dbl_r, sum, sum_r;

   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, n_in}) ? dbl - {1'b0, n_in} : dbl;
      sum   = dbl_r + {1'b0, a_in};
      sum_r = (sum >= {1'b0, n_in}) ? sum - {1'b0, n_in} : sum;
      acc_in  = acc_ff;
      b_in_nx = b_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = run_ff && (cnt_ff == CW'(1));
      if (ctl.start) begin
         acc_in  = '0;
         b_in_nx = b_in;
         cnt_in  = CW'(WIDTH);
         run_in  = 1'b1;
      end else if (run_ff) begin
         acc_in  = b_ff[WIDTH-1] ? sum_r[WIDTH-1:0] : dbl_r[WIDTH-1:0];
         b_in_nx = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      b_ff   <= b_in_nx;
   end

   assign prod = acc_ff;
   assign done = done_ff;
endmodule

@@ hdl/lucas_sequence_ladder_unit.sv @@
`timescale 1ns / 1ps
// channel | dir | beat contents
// req     | in  | a=index_k b=disc_d c=param_p d=modulus_n
// rsp     | out | a=u_term b=v_term e=bad_modulus
// one item at a time; two reductions, then per index bit up to 7 multiplies
// plus the SEEK, DBL_FIN and ADD_FIN control states; the worst case
// is set by the single shared bit-serial multiplier
// an even modulus goes straight to ST_DONE; synchronous active-high reset
// a new req beat is taken once the rsp register is free; rsp stalls hold it
module lucas_sequence_ladder_unit #(
   parameter int unsigned WIDTH = lsl_pkg::DefaultWidth
) (
   input  logic clock,
   input  logic reset,
   lsl_if.sink   req,
   lsl_if.source rsp
);
   import lsl_pkg::*;
   localparam int unsigned BW = $clog2(WIDTH);

   state_type state_ff, state_in;
   logic [WIDTH-1:0] k_ff, d_ff, p_ff, n_ff, u_ff, v_ff, t_ff, x_ff;
   logic [BW-1:0]    bit_ff;
   logic             bit_set_ff;
   logic [WIDTH-1:0] ou_ff, ov_ff;
   logic             obad_ff, ovld_ff;
   mul_ctl_type      mctl;
   logic [WIDTH-1:0] ma, mb, prod;
   logic             mdone;

   lsl_mulmod #(.WIDTH(WIDTH)) u_mul (
      .clock(clock), .reset(reset), .ctl(mctl),
      .a_in(ma), .b_in(mb), .n_in(n_ff), .prod(prod), .done(mdone)
   );

   // modular add and halving
   function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] a, b, n);
      logic [WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, n}) s = s - {1'b0, n};
      return s[WIDTH-1:0];
   endfunction
   function automatic logic [WIDTH-1:0] halfm(input logic [WIDTH-1:0] x, n);
      logic [WIDTH:0] s;
      s = x[0] ? ({1'b0, x} + {1'b0, n}) : {1'b0, x};
      return s[WIDTH:1];
   endfunction

   logic mul_issue_ff;
   logic [WIDTH-1:0] one_n, two_n;
   assign one_n = (n_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
   assign two_n = addm(one_n, one_n, n_ff);

   assign req.ready = (state_ff == ST_IDLE) && !ovld_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req.valid && req.ready)
                       state_in = req.d[0] ? ST_RED_D : ST_DONE;
         ST_RED_D:  if (mdone) state_in = ST_RED_P;
         ST_RED_P:  if (mdone) state_in = ST_SEEK;
         ST_SEEK:   if (k_ff == '0 || bit_ff == '0) state_in = ST_DONE;
                    else if (bit_set_ff) state_in = ST_DBL_UV;
         ST_DBL_UV: if (mdone) state_in = ST_DBL_VV;
         ST_DBL_VV: if (mdone) state_in = ST_DBL_TT;
         ST_DBL_TT: if (mdone) state_in = ST_DBL_DT;
         ST_DBL_DT: if (mdone) state_in = ST_DBL_FIN;
         ST_DBL_FIN: state_in = k_ff[bit_ff - 1'b1] ? ST_ADD_PU : ST_SEEK;
         ST_ADD_PU: if (mdone) state_in = ST_ADD_DT;
         ST_ADD_DT: if (mdone) state_in = ST_ADD_PV;
         ST_ADD_PV: if (mdone) state_in = ST_ADD_FIN;
         ST_ADD_FIN: state_in = ST_SEEK;
         ST_DONE:   if (!ovld_ff) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // multiplier operands and start pulse
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         ST_RED_D:  begin ma = one_n; mb = d_ff; end
         ST_RED_P:  begin ma = one_n; mb = p_ff; end
         ST_DBL_UV: begin ma = u_ff;  mb = v_ff; end
         ST_DBL_VV: begin ma = v_ff;  mb = v_ff; end
         ST_DBL_TT: begin ma = t_ff;  mb = t_ff; end
         ST_DBL_DT: begin ma = d_ff;  mb = x_ff; end
         ST_ADD_PU: begin ma = p_ff;  mb = u_ff; end
         ST_ADD_DT: begin ma = d_ff;  mb = t_ff; end
         ST_ADD_PV: begin ma = p_ff;  mb = v_ff; end
         default:   begin ma = '0;    mb = '0;   end
      endcase
      mctl.start = !mul_issue_ff && (state_ff == ST_RED_D || state_ff == ST_RED_P ||
                   state_ff == ST_DBL_UV || state_ff == ST_DBL_VV ||
                   state_ff == ST_DBL_TT || state_ff == ST_DBL_DT ||
                   state_ff == ST_ADD_PU || state_ff == ST_ADD_DT ||
                   state_ff == ST_ADD_PV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ovld_ff      <= 1'b0;
         mul_issue_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mctl.start) mul_issue_ff <= 1'b1;
         else if (mdone) mul_issue_ff <= 1'b0;
         if (rsp.valid && rsp.ready) ovld_ff <= 1'b0;
         if (state_ff == ST_DONE && !ovld_ff) ovld_ff <= 1'b1;
      end
      unique case (state_ff)
         // capture only while no rsp beat is pending, so rsp.e holds
         ST_IDLE: if (req.ready) begin
            k_ff <= req.a; d_ff <= req.b; p_ff <= req.c; n_ff <= req.d;
            bit_ff <= BW'(WIDTH - 1);
            bit_set_ff <= 1'b0;
            obad_ff <= !req.d[0];
         end
         ST_RED_D: if (mdone) d_ff <= prod;
         ST_RED_P: if (mdone) begin
            p_ff <= prod; u_ff <= one_n; v_ff <= prod;
            bit_set_ff <= k_ff[WIDTH-1];
         end
         ST_SEEK: if (!bit_set_ff && bit_ff != '0) begin
            bit_ff <= bit_ff - 1'b1;
            bit_set_ff <= k_ff[bit_ff - 1'b1];
         end
         ST_DBL_UV: if (mdone) begin t_ff <= u_ff; u_ff <= prod; end
         ST_DBL_VV: if (mdone) v_ff <= prod;
         ST_DBL_TT: if (mdone) x_ff <= prod;
         ST_DBL_DT: if (mdone) x_ff <= prod;
         ST_DBL_FIN: begin
            v_ff <= halfm(addm(v_ff, x_ff, n_ff), n_ff);
            bit_ff <= bit_ff - 1'b1;
            t_ff <= u_ff;
         end
         ST_ADD_PU: if (mdone) x_ff <= prod;
         ST_ADD_DT: if (mdone) begin
            u_ff <= halfm(addm(x_ff, v_ff, n_ff), n_ff);
            x_ff <= prod;
         end
         ST_ADD_PV: if (mdone) v_ff <= halfm(addm(x_ff, prod, n_ff), n_ff);
         ST_DONE: if (!ovld_ff) begin
            ou_ff <= obad_ff ? '0 : (k_ff == '0 ? '0 : u_ff);
            ov_ff <= obad_ff ? '0 : (k_ff == '0 ? two_n : v_ff);
         end
         default: ;
      endcase
   end

   assign rsp.valid = ovld_ff;
   assign rsp.a = ou_ff;
   assign rsp.b = ov_ff;
   assign rsp.c = '0;
   assign rsp.d = '0;
   assign rsp.e = obad_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("rsp dropped");
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      mctl.start |=> !mctl.start) else $error("double multiply start");
`endif
endmodule
